// ===== sv/encoder_count_and_speed_assert.svh =====
// assertion helpers for the encoder counter, clocked on clk, off during reset
`ifndef ENCODER_COUNT_AND_SPEED_ASSERT_SVH
`define ENCODER_COUNT_AND_SPEED_ASSERT_SVH

// plain property check
`define ECS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("encoder_count_and_speed: check failed");

// overlapping implication check
`define ECS_IMPLIES(lbl, ante, cons) `ECS_ASSERT(lbl, (ante) |-> (cons))

`endif

// ===== sv/ecs_pkg.sv =====
package ecs_pkg;

  // state widths
  localparam int COUNT_BITS = 16;
  localparam int TIME_BITS  = 32;

  // fixed port widths
  localparam int CFG_W     = 16;
  localparam int POS_W     = 16;
  localparam int SPEED_W   = 41;
  localparam int TIME_IN_W = 32;
  localparam int CFG_IDX_W = 2;

  // datapath widths
  localparam int WIDE_BITS = (COUNT_BITS > CFG_W) ? COUNT_BITS : CFG_W;
  localparam int DELTA_W   = WIDE_BITS + 2;
  localparam int MAG_W     = DELTA_W - 1;
  localparam int PROD_W    = MAG_W + CFG_W;
  localparam int DIV_CNT_W = $clog2(PROD_W + 1);

  // reset values of the registers
  localparam logic [CFG_W-1:0] COUNT_TOP_RST      = CFG_W'(10000);
  localparam logic [CFG_W-1:0] JUMP_THRESHOLD_RST = CFG_W'(2000);
  localparam logic [CFG_W-1:0] RPM_SCALE_RST      = CFG_W'(60);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT_TOP      = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_JUMP_THRESHOLD = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_RPM_SCALE      = CFG_IDX_W'(2);

  // item kinds
  localparam logic OP_EDGE   = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DELTA,
    ST_MUL,
    ST_DIV,
    ST_SIGN,
    ST_DONE
  } state_t;

endpackage

// ===== sv/encoder_count_and_speed.sv =====
// Quadrature encoder counter with speed estimate, one wheel channel. An edge item
// (in_op = 0) moves the wrapping position count up when in_b_level is high and down
// when it is low; the count wraps from count_top to 0 and back. A sample item
// (in_op = 1) takes the count change since the previous sample, fixes it up by
// count_top+1 when its size reaches jump_threshold, multiplies by rpm_scale and
// divides by the elapsed milliseconds, truncating toward zero. No elapsed time gives
// speed 0 with out_zero_interval set. Every item gives exactly one result item.
// Order: an edge item goes from ST_IDLE straight to ST_DONE; a sample item
// passes ST_DELTA, ST_MUL, ST_DIV and ST_SIGN before ST_DONE, with ST_DIV a
// restoring divider that produces one quotient bit per cycle, and a sample with
// no elapsed time skips the divider and ST_SIGN. The block takes one item at a
// time; in_ready is high only while it waits for an item. The result sits in an
// output register, so a stalled consumer only delays the next item by the time it
// holds that register. Configuration writes are always taken (cfg_ready stays high)
// and belong in idle time only; a write to an index beyond the list is dropped.
module encoder_count_and_speed
  import ecs_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  // item input
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      in_op,
  input  logic                      in_b_level,
  input  logic [TIME_IN_W-1:0]      in_time_ms,
  // result output
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [POS_W-1:0]          out_position,
  output logic signed [SPEED_W-1:0] out_speed,
  output logic                      out_zero_interval,
  // register writes
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_W-1:0]          cfg_data
);

  // sequencer and control state
  state_t                state_r, state_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [DIV_CNT_W-1:0]  cnt_r, cnt_nxt;

  // configuration registers
  logic [CFG_W-1:0]      count_top_r, count_top_nxt;
  logic [CFG_W-1:0]      jump_threshold_r, jump_threshold_nxt;
  logic [CFG_W-1:0]      rpm_scale_r, rpm_scale_nxt;

  // encoder state
  logic [COUNT_BITS-1:0] pos_r, pos_nxt;
  logic [COUNT_BITS-1:0] last_count_r, last_count_nxt;
  logic [TIME_BITS-1:0]  last_time_r, last_time_nxt;

  // working registers of one sample
  logic [TIME_BITS-1:0]  elapsed_r, elapsed_nxt;
  logic                  delta_neg_r, delta_neg_nxt;
  logic [MAG_W-1:0]      mag_r, mag_nxt;
  logic [PROD_W-1:0]     quo_r, quo_nxt;
  logic [TIME_BITS-1:0]  rem_r, rem_nxt;

  // pending result and output register
  logic [SPEED_W-1:0]    res_speed_r, res_speed_nxt;
  logic                  res_zero_r, res_zero_nxt;
  logic [POS_W-1:0]      out_position_r, out_position_nxt;
  logic [SPEED_W-1:0]    out_speed_r, out_speed_nxt;
  logic                  out_zero_r, out_zero_nxt;

  // combinational helpers
  logic                  in_accept;
  logic [WIDE_BITS-1:0]  pos_wide;
  logic [WIDE_BITS-1:0]  top_wide;
  logic [COUNT_BITS-1:0] pos_edge;
  logic signed [DELTA_W-1:0] cur_s, prev_s, thr_s, mod_s;
  logic signed [DELTA_W-1:0] diff_s, diff_mag_s, fixed_s, fixed_mag_s;
  logic                  wrap;
  logic [TIME_BITS:0]    trial;
  logic [TIME_BITS:0]    trial_diff;
  logic                  trial_ge;
  logic [63:0]           quo_64;

  assign in_ready          = (state_r == ST_IDLE);
  assign in_accept         = in_valid && in_ready;
  assign cfg_ready         = 1'b1;
  assign out_valid         = out_valid_r;
  assign out_position      = out_position_r;
  assign out_speed         = out_speed_r;
  assign out_zero_interval = out_zero_r;

  // edge step: wrap to 0 above the top, to the top below 0
  always_comb begin
    pos_wide = WIDE_BITS'(pos_r);
    top_wide = WIDE_BITS'(count_top_r);
    if (in_b_level) begin
      pos_edge = (pos_wide >= top_wide) ? '0 : pos_r + 1'b1;
    end else begin
      pos_edge = (pos_r == '0) ? COUNT_BITS'(count_top_r) : pos_r - 1'b1;
    end
  end

  // count change with wrap fix-up, all in signed arithmetic
  always_comb begin
    cur_s      = DELTA_W'(pos_r);
    prev_s     = DELTA_W'(last_count_r);
    thr_s      = DELTA_W'(jump_threshold_r);
    mod_s      = DELTA_W'(count_top_r) + DELTA_W'(1);
    diff_s     = cur_s - prev_s;
    diff_mag_s = (diff_s < 0) ? -diff_s : diff_s;
    wrap       = (diff_mag_s >= thr_s);
    if (!wrap) begin
      fixed_s = diff_s;
    end else if (cur_s > thr_s) begin
      fixed_s = diff_s - mod_s;
    end else begin
      fixed_s = diff_s + mod_s;
    end
    fixed_mag_s = (fixed_s < 0) ? -fixed_s : fixed_s;
  end

  // one restoring divider step: remainder stays below the divisor
  always_comb begin
    trial      = {rem_r, quo_r[PROD_W-1]};
    trial_diff = trial - {1'b0, elapsed_r};
    trial_ge   = (trial >= {1'b0, elapsed_r});
    quo_64     = 64'(quo_r);
  end

  // sequencer: next state and datapath loads
  always_comb begin
    state_nxt          = state_r;
    out_valid_nxt      = out_valid_r;
    cnt_nxt            = cnt_r;
    count_top_nxt      = count_top_r;
    jump_threshold_nxt = jump_threshold_r;
    rpm_scale_nxt      = rpm_scale_r;
    pos_nxt            = pos_r;
    last_count_nxt     = last_count_r;
    last_time_nxt      = last_time_r;
    elapsed_nxt        = elapsed_r;
    delta_neg_nxt      = delta_neg_r;
    mag_nxt            = mag_r;
    quo_nxt            = quo_r;
    rem_nxt            = rem_r;
    res_speed_nxt      = res_speed_r;
    res_zero_nxt       = res_zero_r;
    out_position_nxt   = out_position_r;
    out_speed_nxt      = out_speed_r;
    out_zero_nxt       = out_zero_r;

    // consumer takes the result item
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    // register writes, to be made only while idle; the block does not enforce it
    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_COUNT_TOP:      count_top_nxt      = cfg_data;
        CFG_JUMP_THRESHOLD: jump_threshold_nxt = cfg_data;
        CFG_RPM_SCALE:      rpm_scale_nxt      = cfg_data;
        default:            ;
      endcase
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          if (in_op == OP_EDGE) begin
            pos_nxt       = pos_edge;
            res_speed_nxt = '0;
            res_zero_nxt  = 1'b0;
            state_nxt     = ST_DONE;
          end else begin
            elapsed_nxt   = TIME_BITS'(in_time_ms) - last_time_r;
            last_time_nxt = TIME_BITS'(in_time_ms);
            state_nxt     = ST_DELTA;
          end
        end
      end
      ST_DELTA: begin
        delta_neg_nxt  = (fixed_s < 0);
        mag_nxt        = MAG_W'(fixed_mag_s);
        last_count_nxt = pos_r;
        state_nxt      = ST_MUL;
      end
      ST_MUL: begin
        quo_nxt = {{CFG_W{1'b0}}, mag_r} * {{MAG_W{1'b0}}, rpm_scale_r};
        rem_nxt = '0;
        cnt_nxt = '0;
        if (elapsed_r == '0) begin
          res_speed_nxt = '0;
          res_zero_nxt  = 1'b1;
          state_nxt     = ST_DONE;
        end else begin
          res_zero_nxt = 1'b0;
          state_nxt    = ST_DIV;
        end
      end
      ST_DIV: begin
        rem_nxt = trial_ge ? trial_diff[TIME_BITS-1:0] : trial[TIME_BITS-1:0];
        quo_nxt = {quo_r[PROD_W-2:0], trial_ge};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_W'(PROD_W - 1)) begin
          state_nxt = ST_SIGN;
        end
      end
      ST_SIGN: begin
        res_speed_nxt = SPEED_W'(delta_neg_r ? (64'd0 - quo_64) : quo_64);
        state_nxt     = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_position_nxt = POS_W'(pos_r);
          out_speed_nxt    = res_speed_r;
          out_zero_nxt     = res_zero_r;
          out_valid_nxt    = 1'b1;
          state_nxt        = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= ST_IDLE;
      out_valid_r      <= 1'b0;
      count_top_r      <= COUNT_TOP_RST;
      jump_threshold_r <= JUMP_THRESHOLD_RST;
      rpm_scale_r      <= RPM_SCALE_RST;
      pos_r            <= '0;
      last_count_r     <= '0;
      last_time_r      <= '0;
    end else begin
      state_r          <= state_nxt;
      out_valid_r      <= out_valid_nxt;
      count_top_r      <= count_top_nxt;
      jump_threshold_r <= jump_threshold_nxt;
      rpm_scale_r      <= rpm_scale_nxt;
      pos_r            <= pos_nxt;
      last_count_r     <= last_count_nxt;
      last_time_r      <= last_time_nxt;
    end
  end

  // payload and working registers
  always_ff @(posedge clk) begin
    cnt_r          <= cnt_nxt;
    elapsed_r      <= elapsed_nxt;
    delta_neg_r    <= delta_neg_nxt;
    mag_r          <= mag_nxt;
    quo_r          <= quo_nxt;
    rem_r          <= rem_nxt;
    res_speed_r    <= res_speed_nxt;
    res_zero_r     <= res_zero_nxt;
    out_position_r <= out_position_nxt;
    out_speed_r    <= out_speed_nxt;
    out_zero_r     <= out_zero_nxt;
  end

`include "encoder_count_and_speed_assert.svh"

  // an accepted item keeps the block busy in the following cycle
  `ECS_ASSERT(a_busy_after_accept, (in_valid && in_ready) |=> !in_ready)
  // a sample with no elapsed time reports zero speed
  `ECS_IMPLIES(a_zero_interval_speed, out_valid && out_zero_interval, out_speed == '0)
  // the position only moves on an accepted edge item
  `ECS_IMPLIES(a_pos_moves_on_edge, $past(rst_n) && (pos_r != $past(pos_r)),
               $past(in_valid && in_ready && (in_op == OP_EDGE)))
  // the divider remainder stays below the divisor
  `ECS_IMPLIES(a_div_rem_below, state_r == ST_DIV, rem_r < elapsed_r)

endmodule

// ===== test/tb_encoder_count_and_speed.sv =====
module tb_encoder_count_and_speed;
  timeunit 1ns;
  timeprecision 1ps;
  import ecs_pkg::*;

  // run limits
  localparam int CYCLE_LIMIT  = 500000;
  localparam int DRAIN_CYCLES = 60;    // longer than a sample item takes to finish
  // index past the register list, the write must be dropped
  localparam logic [CFG_IDX_W-1:0] CFG_NO_REG = CFG_IDX_W'(3);

  // one result item as the block should produce it
  typedef struct {
    logic [POS_W-1:0]          pos;
    logic signed [SPEED_W-1:0] speed;
    logic                      zero_int;
  } enc_result_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic                      in_op = OP_EDGE;
  logic                      in_b_level = 1'b0;
  logic [TIME_IN_W-1:0]      in_time_ms = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic [POS_W-1:0]          out_position;
  logic signed [SPEED_W-1:0] out_speed;
  logic                      out_zero_interval;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_IDX_W-1:0]      cfg_index = CFG_COUNT_TOP;
  logic [CFG_W-1:0]          cfg_data = '0;

  // predictor copy of registers and state
  logic [CFG_W-1:0]      top_r = COUNT_TOP_RST;
  logic [CFG_W-1:0]      thr_r = JUMP_THRESHOLD_RST;
  logic [CFG_W-1:0]      scale_r = RPM_SCALE_RST;
  logic [COUNT_BITS-1:0] pos_cnt = '0;
  logic [COUNT_BITS-1:0] last_cnt = '0;
  logic [TIME_BITS-1:0]  last_ms = '0;

  enc_result_t pending_results[$];
  int          mismatch_count = 0;
  int          cycle_count = 0;
  bit          idle_en = 1'b1;       // random gaps on both sides
  logic [31:0] sample_ms = '0;      // running time base for well-formed samples
  int          stall_left = 0;

  encoder_count_and_speed dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_op             (in_op),
    .in_b_level        (in_b_level),
    .in_time_ms        (in_time_ms),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_position      (out_position),
    .out_speed         (out_speed),
    .out_zero_interval (out_zero_interval),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // hard stop in case the block hangs
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // position and speed of one item, advances the predictor state
  function automatic enc_result_t predict_position_speed(logic op, logic b, logic [31:0] t);
    enc_result_t r;
    longint      cur, prev, thr, modl, delta, mag;
    logic [63:0] amag, quot;
    logic [TIME_BITS-1:0] elapsed;
    logic        neg;
    r.speed    = '0;
    r.zero_int = 1'b0;
    if (op == OP_EDGE) begin
      if (b) begin
        // up: wraps to 0 at or above the top
        pos_cnt = (pos_cnt >= top_r) ? '0 : pos_cnt + 1'b1;
      end else begin
        // down: wraps from 0 to the top
        pos_cnt = (pos_cnt == '0) ? top_r : pos_cnt - 1'b1;
      end
    end else begin
      cur     = longint'(pos_cnt);
      prev    = longint'(last_cnt);
      thr     = longint'(thr_r);
      modl    = longint'(top_r) + 1;
      delta   = cur - prev;
      mag     = (delta < 0) ? -delta : delta;
      elapsed = t - last_ms;
      // big jump means the count wrapped between samples
      if (mag >= thr) begin
        if (cur - thr > 0) begin
          delta = cur - modl - prev;
        end else begin
          delta = cur + modl - prev;
        end
      end
      if (elapsed == '0) begin
        r.zero_int = 1'b1;
      end else begin
        neg     = (delta < 0);
        amag    = neg ? 64'(-delta) : 64'(delta);
        quot    = (amag * {48'd0, scale_r}) / {32'd0, elapsed};
        amag    = neg ? (64'd0 - quot) : quot;
        r.speed = amag[SPEED_W-1:0];
      end
      last_cnt = pos_cnt;
      last_ms  = t;
    end
    r.pos = pos_cnt;
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch at %0t ns: %s got %0d expected %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  // result checker
  always @(posedge clk) begin
    enc_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result item with nothing pending, position", out_position, 0);
      end else begin
        want = pending_results.pop_front();
        if (out_position !== want.pos)
          report_mismatch("position", out_position, want.pos);
        if (out_speed !== want.speed)
          report_mismatch("speed", out_speed, want.speed);
        if (out_zero_interval !== want.zero_int)
          report_mismatch("zero_interval", out_zero_interval, want.zero_int);
      end
    end
  end

  // consumer side: random stall bursts
  always @(negedge clk) begin
    if (stall_left != 0) begin
      stall_left--;
    end else if (idle_en && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(1, 14);
    end
    out_ready <= (stall_left == 0);
  end

  // sends one item; returns at the edge where it was taken
  task automatic send_item(logic op, logic b, logic [31:0] t);
    int gap;
    @(negedge clk);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 14);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_op      <= op;
    in_b_level <= b;
    in_time_ms <= t;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(predict_position_speed(op, b, t));
  endtask

  task automatic edge_item(logic b);
    send_item(OP_EDGE, b, $urandom);
  endtask

  task automatic sample_item(logic [31:0] t);
    send_item(OP_SAMPLE, 1'($urandom_range(0, 1)), t);
  endtask

  // stop sending and let every pending result come out
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_COUNT_TOP:      top_r   = data;
      CFG_JUMP_THRESHOLD: thr_r   = data;
      CFG_RPM_SCALE:      scale_r = data;
      default: ;  // dropped by the block
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // registers only change with the block idle
  task automatic set_regs(logic [CFG_W-1:0] top, logic [CFG_W-1:0] thr, logic [CFG_W-1:0] scale);
    drain();
    write_reg(CFG_COUNT_TOP, top);
    write_reg(CFG_JUMP_THRESHOLD, thr);
    write_reg(CFG_RPM_SCALE, scale);
  endtask

  // reset registers: wrap both ways, wrap correction both ways, no elapsed time,
  // time wrapping past all ones
  task automatic test_edge_wrap();
    sample_item(32'd0);            // same time as reset sample
    edge_item(1'b0);               // 0 wraps down to the top
    sample_item(32'd10);           // jump seen as a backward wrap
    edge_item(1'b1);               // top wraps up to 0
    sample_item(32'd13);           // jump seen as a forward wrap
    repeat (3) edge_item(1'b1);
    sample_item(32'd20);           // truncated quotient
    repeat (2) edge_item(1'b0);
    send_item(OP_EDGE, 1'b1, 32'hFFFF_FFFF);
    edge_item(1'b0);
    sample_item(32'hFFFF_FFF0);
    sample_item(32'h0000_0004);    // elapsed time wraps
  endtask

  // largest register values, widest speed, then the smallest ones
  task automatic test_extreme_regs();
    set_regs(16'hFFFF, 16'hFFFF, 16'hFFFF);
    edge_item(1'b0);
    sample_item(32'd100);
    edge_item(1'b0);
    sample_item(32'd101);          // one ms, largest magnitude
    set_regs(16'd1, 16'd1, 16'd1);
    edge_item(1'b1);
    edge_item(1'b1);
    sample_item(32'd103);
    edge_item(1'b0);
    sample_item(32'd200);
  endtask

  // lowering the top below the count
  task automatic test_count_above_top();
    set_regs(16'hFFFF, 16'd2000, 16'd60);
    repeat (3) edge_item(1'b0);
    set_regs(16'd100, 16'd2000, 16'd60);
    edge_item(1'b0);               // just decrements above the top
    edge_item(1'b1);               // wraps to 0
    sample_item(32'd250);
  endtask

  // zero in every register, and a write past the register list
  task automatic test_zero_regs();
    set_regs(16'd0, 16'd0, 16'd0);
    edge_item(1'b1);
    edge_item(1'b0);
    sample_item(32'd260);
    drain();
    write_reg(CFG_NO_REG, 16'hFFFF);
    set_regs(16'd50, 16'd0, 16'd7);
    edge_item(1'b1);
    sample_item(32'd270);          // every change treated as a wrap
  endtask

  // runs of edges mostly one way, then a sample; some noise in the times
  task automatic run_motion(int n_items, int max_run);
    int          sent;
    int          run;
    logic        dir;
    logic [31:0] t;
    sent = 0;
    while (sent < n_items) begin
      run = $urandom_range(0, max_run);
      dir = 1'($urandom_range(0, 1));
      for (int i = 0; i < run && sent < n_items; i++) begin
        edge_item(($urandom_range(0, 9) < 8) ? dir : ~dir);
        sent++;
      end
      case ($urandom_range(0, 19))
        0:       t = $urandom;                 // arbitrary time
        1:       t = sample_ms;                // no elapsed time
        2:       t = sample_ms + $urandom_range(1, 65535);
        default: t = sample_ms + $urandom_range(1, 200);
      endcase
      sample_ms = t;
      sample_item(t);
      sent++;
    end
  endtask

  task automatic test_random_motion();
    logic [CFG_W-1:0] top;
    set_regs(COUNT_TOP_RST, JUMP_THRESHOLD_RST, RPM_SCALE_RST);
    sample_ms = $urandom;
    run_motion(120, 40);
    top = CFG_W'($urandom_range(1, 30));
    set_regs(top, CFG_W'($urandom_range(1, top)), CFG_W'($urandom_range(1, 65535)));
    run_motion(120, 60);
    set_regs(16'hFFFF, CFG_W'($urandom_range(1, 65535)), 16'hFFFF);
    run_motion(120, 30);
    set_regs(CFG_W'($urandom_range(1, 65535)), CFG_W'($urandom_range(1, 65535)),
             CFG_W'($urandom_range(1, 65535)));
    run_motion(120, 50);
    // last stretch at full rate on both sides
    top = CFG_W'($urandom_range(2, 200));
    set_regs(top, CFG_W'($urandom_range(1, top)), CFG_W'($urandom_range(1, 1000)));
    idle_en = 1'b0;
    run_motion(120, 30);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_edge_wrap();
    test_extreme_regs();
    test_count_above_top();
    test_zero_regs();
    test_random_motion();
    drain();
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/ecs_pkg.sv
sv/encoder_count_and_speed.sv
test/tb_encoder_count_and_speed.sv
